// ===== src/rgbhsl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsl_pkg
// Shared widths, constants and types for the RGB to HSL pixel converter.
// ----------------------------------------------------------------------------
package rgbhsl_pkg;

  // fractional bits of hue and saturation
  localparam int FRAC_BITS = 6;

  // field widths
  localparam int PIX_W   = 24;
  localparam int COMP_W  = 8;
  localparam int HUE_W   = 15;
  localparam int SAT_W   = 13;
  localparam int LIGHT_W = 9;
  localparam int N_W     = 11;

  // scale factors of hue (degrees per sixth) and saturation (percent)
  localparam int HUE_MULT = 60;
  localparam int SAT_MULT = 100;

  // rgb565 field layout
  localparam int R5_LSB = 11;
  localparam int G6_LSB = 5;

  // quotient bits: hue is at most 360 * 2^FRAC_BITS, which needs 9 + FRAC_BITS bits
  localparam int QUO_W = 9 + FRAC_BITS;
  // divisors are 8-bit chroma or lightness terms
  localparam int DIV_W = COMP_W;
  // numerators stay below divisor * 2^QUO_W
  localparam int NUM_W = QUO_W + DIV_W;

  // pixel format register codes
  typedef enum logic {
    FMT_RGB888 = 1'b0,
    FMT_RGB565 = 1'b1
  } fmt_t;

  // one lane of the restoring divider
  typedef struct packed {
    logic [DIV_W-1:0] divisor;
    logic [DIV_W-1:0] rem;
    logic [QUO_W-1:0] acc;
  } div_lane_t;

  // one stage of the divider pipeline
  typedef struct packed {
    logic               valid;
    logic               zero;
    logic [LIGHT_W-1:0] light;
    div_lane_t          hue;
    div_lane_t          sat;
  } div_stage_t;

endpackage

// ===== src/rgbhsl_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsl channel interfaces
// Valid/ready channels for the pixel input and the hsl result output.
// ----------------------------------------------------------------------------

// pixel input channel
interface rgbhsl_pix_if;
  logic                         valid;
  logic                         ready;
  logic [rgbhsl_pkg::PIX_W-1:0] pixel_word;

  modport source (output valid, output pixel_word, input ready);
  modport sink (input valid, input pixel_word, output ready);
endinterface

// hsl result channel
interface rgbhsl_hsl_if;
  logic                           valid;
  logic                           ready;
  logic [rgbhsl_pkg::HUE_W-1:0]   hue_fixed;
  logic [rgbhsl_pkg::SAT_W-1:0]   saturation_fixed;
  logic [rgbhsl_pkg::LIGHT_W-1:0] lightness_sum;

  modport source (output valid, output hue_fixed, output saturation_fixed,
                  output lightness_sum, input ready);
  modport sink (input valid, input hue_fixed, input saturation_fixed,
                input lightness_sum, output ready);
endinterface

// ===== src/rgbhsl_div_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsl_div_pipe
// Two-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rgbhsl_div_pipe (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  rgbhsl_pkg::div_stage_t load,
  output rgbhsl_pkg::div_stage_t result
);

  localparam int QUO_W = rgbhsl_pkg::QUO_W;
  localparam int DIV_W = rgbhsl_pkg::DIV_W;

  rgbhsl_pkg::div_stage_t stage [0:QUO_W];

  // one restoring step: shift in the next numerator bit, subtract if it fits
  function automatic rgbhsl_pkg::div_lane_t div_step(input rgbhsl_pkg::div_lane_t l);
    logic [DIV_W:0]        t;
    logic                  take;
    rgbhsl_pkg::div_lane_t o;
    t         = {l.rem, l.acc[QUO_W-1]};
    take      = (t >= {1'b0, l.divisor});
    o.divisor = l.divisor;
    o.rem     = take ? DIV_W'(t - {1'b0, l.divisor}) : t[DIV_W-1:0];
    o.acc     = {l.acc[QUO_W-2:0], take};
    return o;
  endfunction

  // stage registers, all advance together on enable
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= QUO_W; k++) begin
        stage[k].valid <= 1'b0;
      end
    end else if (en) begin
      stage[0] <= load;
      for (int k = 1; k <= QUO_W; k++) begin
        stage[k].valid <= stage[k-1].valid;
        stage[k].zero  <= stage[k-1].zero;
        stage[k].light <= stage[k-1].light;
        stage[k].hue   <= div_step(stage[k-1].hue);
        stage[k].sat   <= div_step(stage[k-1].sat);
      end
    end
  end

  assign result = stage[QUO_W];

endmodule

// ===== src/rgb_to_hsl_pixel_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsl_pixel_converter
// Converts RGB888 or RGB565 pixels to hue, saturation and lightness sum.
// ----------------------------------------------------------------------------
// Usage:
//   pix_in carries one pixel per item; hsl_out carries one result per item,
//   in input order. cfg_wr_en/cfg_wr_data set the pixel format (0 = RGB888,
//   1 = RGB565); write it only while no item is in flight.
//   Throughput: one item per clock. The block takes a new pixel every cycle
//   while results keep draining.
//   Depth: two front stages unpack the pixel and form the numerators;
//   the restoring dividers then retire one quotient bit per stage, which
//   sets the depth (QUO_W = 9 + fraction bits).
//   Reset: all stage valid bits clear, the format returns to RGB565.
//   Stall: when a result waits with ready low, the whole pipeline holds and
//   pix_in.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module rgb_to_hsl_pixel_converter (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  rgbhsl_pix_if.sink          pix_in,
  rgbhsl_hsl_if.source        hsl_out
);

  localparam int COMP_W  = rgbhsl_pkg::COMP_W;
  localparam int LIGHT_W = rgbhsl_pkg::LIGHT_W;
  localparam int N_W     = rgbhsl_pkg::N_W;
  localparam int NUM_W   = rgbhsl_pkg::NUM_W;
  localparam int QUO_W   = rgbhsl_pkg::QUO_W;
  localparam int DIV_W   = rgbhsl_pkg::DIV_W;

  rgbhsl_pkg::fmt_t input_format;

  logic en;

  logic [COMP_W-1:0] r_in, g_in, b_in, v_in, m_in;

  logic              s1_valid;
  logic [COMP_W-1:0] s1_r, s1_g, s1_b, s1_v, s1_m;

  logic [COMP_W-1:0]  d_c;
  logic [LIGHT_W-1:0] sum_c;
  logic [N_W-1:0]     n_c;
  logic [COMP_W-1:0]  q_c;

  logic               s2_valid;
  logic [N_W-1:0]     s2_n;
  logic [COMP_W-1:0]  s2_d;
  logic [COMP_W-1:0]  s2_q;
  logic [LIGHT_W-1:0] s2_sum;

  logic [NUM_W-1:0] hue_num, sat_num;

  rgbhsl_pkg::div_stage_t div_load, div_out;

  // format register
  always_ff @(posedge clk) begin
    if (rst) begin
      input_format <= rgbhsl_pkg::FMT_RGB565;
    end else if (cfg_wr_en) begin
      input_format <= rgbhsl_pkg::fmt_t'(cfg_wr_data);
    end
  end

  // pipeline advances unless a result waits at the output
  assign en           = !div_out.valid || hsl_out.ready;
  assign pix_in.ready = en;

  // unpack the pixel into 8-bit components
  always_comb begin
    case (input_format)
      rgbhsl_pkg::FMT_RGB888: begin
        r_in = pix_in.pixel_word[23:16];
        g_in = pix_in.pixel_word[15:8];
        b_in = pix_in.pixel_word[7:0];
      end
      rgbhsl_pkg::FMT_RGB565: begin
        r_in = {pix_in.pixel_word[rgbhsl_pkg::R5_LSB +: 5], 3'b000};
        g_in = {pix_in.pixel_word[rgbhsl_pkg::G6_LSB +: 6], 2'b00};
        b_in = {pix_in.pixel_word[4:0], 3'b000};
      end
      default: begin
        r_in = '0;
        g_in = '0;
        b_in = '0;
      end
    endcase
  end

  // max and min of the components
  always_comb begin
    v_in = (r_in >= g_in) ? r_in : g_in;
    v_in = (v_in >= b_in) ? v_in : b_in;
    m_in = (r_in <= g_in) ? r_in : g_in;
    m_in = (m_in <= b_in) ? m_in : b_in;
  end

  // stage 1: components, max, min
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= pix_in.valid;
      s1_r     <= r_in;
      s1_g     <= g_in;
      s1_b     <= b_in;
      s1_v     <= v_in;
      s1_m     <= m_in;
    end
  end

  // chroma, lightness sum, saturation divisor and hue sector count
  always_comb begin
    d_c   = s1_v - s1_m;
    sum_c = LIGHT_W'(s1_v) + LIGHT_W'(s1_m);
    q_c   = (sum_c <= LIGHT_W'(255)) ? sum_c[COMP_W-1:0]
                                     : COMP_W'(LIGHT_W'(510) - sum_c);
    if (s1_r == s1_v) begin
      n_c = (s1_g == s1_m) ? N_W'(5 * N_W'(d_c)) + N_W'(s1_v - s1_b)
                           : N_W'(d_c) - N_W'(s1_v - s1_g);
    end else if (s1_g == s1_v) begin
      n_c = (s1_b == s1_m) ? N_W'(d_c) + N_W'(s1_v - s1_r)
                           : N_W'(3 * N_W'(d_c)) - N_W'(s1_v - s1_b);
    end else begin
      n_c = (s1_r == s1_m) ? N_W'(3 * N_W'(d_c)) + N_W'(s1_v - s1_g)
                           : N_W'(5 * N_W'(d_c)) - N_W'(s1_v - s1_r);
    end
  end

  // stage 2: divider operands
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
      s2_n     <= n_c;
      s2_d     <= d_c;
      s2_q     <= q_c;
      s2_sum   <= sum_c;
    end
  end

  // scaled numerators, constant multiplies
  assign hue_num = (NUM_W'(NUM_W'(s2_n) * NUM_W'(rgbhsl_pkg::HUE_MULT)))
                   << rgbhsl_pkg::FRAC_BITS;
  assign sat_num = (NUM_W'(NUM_W'(s2_d) * NUM_W'(rgbhsl_pkg::SAT_MULT)))
                   << rgbhsl_pkg::FRAC_BITS;

  // load the divider: upper bits seed the remainder, lower bits shift in
  always_comb begin
    div_load.valid       = s2_valid;
    div_load.zero        = (s2_d == '0);
    div_load.light       = s2_sum;
    div_load.hue.divisor = s2_d;
    div_load.hue.rem     = hue_num[NUM_W-1 -: DIV_W];
    div_load.hue.acc     = hue_num[QUO_W-1:0];
    div_load.sat.divisor = s2_q;
    div_load.sat.rem     = sat_num[NUM_W-1 -: DIV_W];
    div_load.sat.acc     = sat_num[QUO_W-1:0];
  end

  rgbhsl_div_pipe u_div (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .load   (div_load),
    .result (div_out)
  );

  // result item, grey and black pixels force hue and saturation to zero
  assign hsl_out.valid            = div_out.valid;
  assign hsl_out.hue_fixed        = div_out.zero ? '0
                                    : rgbhsl_pkg::HUE_W'(div_out.hue.acc);
  assign hsl_out.saturation_fixed = div_out.zero ? '0
                                    : rgbhsl_pkg::SAT_W'(div_out.sat.acc);
  assign hsl_out.lightness_sum    = div_out.light;

endmodule

// ===== src/rgbhsl_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsl_checker
// Port-level assertions for the RGB to HSL pixel converter, bound to the top.
// ----------------------------------------------------------------------------
module rgbhsl_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [rgbhsl_pkg::HUE_W-1:0]   hue_fixed,
  input logic [rgbhsl_pkg::SAT_W-1:0]   saturation_fixed,
  input logic [rgbhsl_pkg::LIGHT_W-1:0] lightness_sum
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result stays and keeps its value
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hue_fixed)
      && $stable(saturation_fixed) && $stable(lightness_sum))
    else $error("stalled result changed");

  // a stalled result holds back the input
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  // hue and saturation are zero together (grey or black) or both nonzero
  a_grey_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((hue_fixed == '0) == (saturation_fixed == '0)))
    else $error("hue and saturation disagree on grey");

  // a grey pixel has max equal to min, so the sum is even
  a_grey_even: assert property (@(posedge clk) disable iff (rst)
    out_valid && (saturation_fixed == '0) |-> !lightness_sum[0])
    else $error("odd lightness sum on grey pixel");

endmodule

bind rgb_to_hsl_pixel_converter rgbhsl_checker u_checker (
  .clk              (clk),
  .rst              (rst),
  .in_ready         (pix_in.ready),
  .out_valid        (hsl_out.valid),
  .out_ready        (hsl_out.ready),
  .hue_fixed        (hsl_out.hue_fixed),
  .saturation_fixed (hsl_out.saturation_fixed),
  .lightness_sum    (hsl_out.lightness_sum)
);
